// File: src/rotated_binary_template_matcher_unit_assert.svh
// Assertion macros for the rotated binary template matcher.
// Depends on nothing; the top level includes it to check its own logic.
`ifndef ROTATED_BINARY_TEMPLATE_MATCHER_UNIT_ASSERT_SVH
`define ROTATED_BINARY_TEMPLATE_MATCHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RBTM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RBTM_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define RBTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/rbtm_pkg.sv
// Types, constants and pattern helpers for the rotated binary template matcher.
// Depends on nothing; used by the interfaces and the top level.
package rbtm_pkg;

  // Field widths.
  localparam int TAG_W   = 16;
  localparam int POS_W   = 10;
  localparam int MASK_W  = 4;
  localparam int WWID_W  = 11;
  localparam int PSIZE_W = 4;
  localparam int PBITS_W = 64;
  localparam int DATA_W  = 64;
  localparam int APB_AW  = 5;

  // The pattern register is laid out as rows of eight cells.
  localparam int PAT_SIDE = 8;

  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [PBITS_W-1:0] pbits_t;
  typedef logic [1:0]         reg_idx_t;
  typedef logic [1:0]         rot_t;

  // Register indexes (byte address is eight times the index).
  localparam reg_idx_t REG_WORLD_WIDTH  = 2'd0;
  localparam reg_idx_t REG_PATTERN_SIZE = 2'd1;
  localparam reg_idx_t REG_PATTERN_BITS = 2'd2;

  // Reset values of the registers.
  localparam logic [WWID_W-1:0]  WORLD_WIDTH_RST  = 11'd64;
  localparam logic [PSIZE_W-1:0] PATTERN_SIZE_RST = 4'd5;

  // Rotation codes, clockwise; the code is also the bit in the result mask.
  localparam rot_t ROT_0   = 2'd0;
  localparam rot_t ROT_90  = 2'd1;
  localparam rot_t ROT_180 = 2'd2;
  localparam rot_t ROT_270 = 2'd3;

  // Expected window contents for one rotation. Window bit k*8+j holds the
  // cell k rows above and j columns left of the newest cell, so the
  // pattern's corner (a, b) lands at k = p-1-a, j = p-1-b.
  function automatic pbits_t rotate_pattern(input pbits_t bits,
                                             input logic [PSIZE_W-1:0] p,
                                             input rot_t rot);
    pbits_t e;
    logic [PSIZE_W-1:0] rk;
    logic [PSIZE_W-1:0] rj;
    logic [2:0] pr;
    logic [2:0] pc;
    e = '0;
    for (int k = 0; k < PAT_SIDE; k++) begin
      for (int j = 0; j < PAT_SIDE; j++) begin
        rk = p - PSIZE_W'(1) - PSIZE_W'(k);
        rj = p - PSIZE_W'(1) - PSIZE_W'(j);
        case (rot)
          ROT_0: begin
            pr = rk[2:0];
            pc = rj[2:0];
          end
          ROT_90: begin
            pr = 3'(j);
            pc = rk[2:0];
          end
          ROT_180: begin
            pr = 3'(k);
            pc = 3'(j);
          end
          default: begin
            pr = rj[2:0];
            pc = 3'(k);
          end
        endcase
        if (PSIZE_W'(k) < p && PSIZE_W'(j) < p) begin
          e[k*PAT_SIDE+j] = bits[{pr, pc}];
        end
      end
    end
    return e;
  endfunction

  // Window cells that take part in a comparison of size p.
  function automatic pbits_t care_mask(input logic [PSIZE_W-1:0] p);
    pbits_t m;
    m = '0;
    for (int k = 0; k < PAT_SIDE; k++) begin
      for (int j = 0; j < PAT_SIDE; j++) begin
        m[k*PAT_SIDE+j] = (PSIZE_W'(k) < p) && (PSIZE_W'(j) < p);
      end
    end
    return m;
  endfunction

endpackage

// File: src/rbtm_if.sv
// Stream interfaces for world cells and match results.
// Depends on rbtm_pkg for the payload types.
interface rbtm_in_if;
  import rbtm_pkg::*;

  logic valid;
  logic ready;
  logic cell_alive;
  logic first_of_frame;
  tag_t frame_tag;

  modport source (output valid, cell_alive, first_of_frame, frame_tag, input ready);
  modport sink   (input valid, cell_alive, first_of_frame, frame_tag, output ready);
endinterface

interface rbtm_out_if;
  import rbtm_pkg::*;

  logic  valid;
  logic  ready;
  pos_t  match_row;
  pos_t  match_col;
  mask_t rotation_mask;
  tag_t  match_frame;

  modport source (output valid, match_row, match_col, rotation_mask, match_frame,
                  input ready);
  modport sink   (input valid, match_row, match_col, rotation_mask, match_frame,
                  output ready);
endinterface

// File: src/rbtm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; a read at the address being written returns old data.
module rbtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/rotated_binary_template_matcher_unit.sv
// Channel  | Dir | Beat payload                                        | Handshake
// cells    | in  | cell_alive, first_of_frame, frame_tag               | valid/ready
// results  | out | match_row, match_col, rotation_mask, match_frame    | valid/ready
// config   | in  | APB writes/reads of world_width, pattern_size, bits | psel/penable
//
// One cell beat is taken every cycle while cells.ready is high. The line store
// RAM is read when a beat enters and written back from the read-back stage,
// with forwarding for back-to-back beats in the same column. After reset a
// clearing pass writes all MAX_WIDTH line store entries, one per cycle, while
// cells.ready stays low. The whole pipeline holds while a result waits in the
// output register and results.ready is low.
//
// Top level of the rotated binary template matcher; depends on rbtm_pkg,
// the stream interfaces, rbtm_ram and the assertion macro header.
`include "rotated_binary_template_matcher_unit_assert.svh"

module rotated_binary_template_matcher_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_PATTERN = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  rbtm_in_if.sink                      cells,
  rbtm_out_if.source                   results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbtm_pkg::APB_AW-1:0]  paddr,
  input  logic [rbtm_pkg::DATA_W-1:0]  pwdata,
  output logic [rbtm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import rbtm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = AW + 1;
  localparam int EW = (PW > WWID_W) ? PW : WWID_W;
  localparam int XW = (PW > POS_W) ? PW : POS_W;
  localparam int MP = MAX_PATTERN;
  localparam int LW = MAX_PATTERN - 1;

  // Configuration registers.
  logic [WWID_W-1:0]  world_width;
  logic [PSIZE_W-1:0] pattern_size;
  pbits_t             pattern_bits;

  // Values derived from the configuration.
  logic [PW-1:0]      eff_width;
  logic [EW-1:0]      ww_ext;
  logic [PSIZE_W-1:0] eff_size;
  logic [PSIZE_W-1:0] eff_size_next;
  pbits_t             rot_exp [4];
  pbits_t             care;

  // Frame position and tag.
  logic [AW-1:0] row_count;
  logic [AW-1:0] col_count;
  tag_t          current_tag;

  // Line store clearing pass.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Pipeline control.
  logic en;
  logic in_acc;

  // Entry stage position logic.
  logic [AW-1:0] row0;
  logic [AW-1:0] col0;
  logic [AW-1:0] col1;
  logic [PW-1:0] rinc;
  logic [AW-1:0] row1;
  logic [PW-1:0] cinc;
  logic [PW-1:0] rnext;
  logic [AW-1:0] row_count_next;
  logic [AW-1:0] col_count_next;
  tag_t          tag0;

  // Read-back stage.
  logic          s1_valid;
  logic          s1_cell;
  logic [AW-1:0] s1_row;
  logic [AW-1:0] s1_col;
  tag_t          s1_tag;
  logic          fwd_hit;
  logic [LW-1:0] fwd_data;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] old_bits;
  logic [MP-1:0] colbits;

  // Window and compare stage.
  logic [MP-1:0][MP-1:0] win;
  logic          s2_valid;
  logic [AW-1:0] s2_row;
  logic [AW-1:0] s2_col;
  tag_t          s2_tag;
  logic [3:0]    mism;
  mask_t         hit_mask;
  logic          fits;
  logic          s2_hit;
  logic [XW-1:0] top_row;
  logic [XW-1:0] left_col;

  // Line store RAM write/read ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;

  // APB register writes.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      world_width  <= WORLD_WIDTH_RST;
      pattern_size <= PATTERN_SIZE_RST;
      pattern_bits <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:3])
        REG_WORLD_WIDTH:  world_width  <= pwdata[WWID_W-1:0];
        REG_PATTERN_SIZE: pattern_size <= pwdata[PSIZE_W-1:0];
        REG_PATTERN_BITS: pattern_bits <= pwdata;
        default: ;
      endcase
    end
  end

  // APB register reads.
  always_comb begin
    case (paddr[4:3])
      REG_WORLD_WIDTH:  prdata = DATA_W'(world_width);
      REG_PATTERN_SIZE: prdata = DATA_W'(pattern_size);
      REG_PATTERN_BITS: prdata = pattern_bits;
      default:          prdata = '0;
    endcase
  end

  // Effective width and pattern size, clamped to the supported range.
  assign ww_ext = EW'(world_width);
  always_comb begin
    if (ww_ext == '0) begin
      eff_width = PW'(1);
    end else if (ww_ext > EW'(MAX_WIDTH)) begin
      eff_width = PW'(MAX_WIDTH);
    end else begin
      eff_width = ww_ext[PW-1:0];
    end
    eff_size_next = (pattern_size > PSIZE_W'(MAX_PATTERN)) ?
                    PSIZE_W'(MAX_PATTERN) : pattern_size;
  end

  // Expected windows for the four rotations, refreshed from the registers.
  always_ff @(posedge clk) begin
    eff_size  <= eff_size_next;
    care      <= care_mask(eff_size_next);
    for (int r = 0; r < 4; r++) begin
      rot_exp[r] <= rotate_pattern(pattern_bits, eff_size_next, rot_t'(r));
    end
  end

  // Clearing pass over the line store after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // The pipeline moves whenever the output register is free or draining.
  assign en          = !results.valid || results.ready;
  assign cells.ready = en && !clearing;
  assign in_acc      = cells.valid && cells.ready;

  // Position of the entering cell, with wraps, and the position after it.
  always_comb begin
    row0 = cells.first_of_frame ? '0 : row_count;
    col0 = cells.first_of_frame ? '0 : col_count;
    tag0 = cells.first_of_frame ? cells.frame_tag : current_tag;
    if ({1'b0, col0} >= eff_width) begin
      col1 = '0;
      rinc = {1'b0, row0} + PW'(1);
    end else begin
      col1 = col0;
      rinc = {1'b0, row0};
    end
    row1  = (rinc >= eff_width) ? '0 : rinc[AW-1:0];
    cinc  = {1'b0, col1} + PW'(1);
    rnext = {1'b0, row1} + PW'(1);
    if (cinc >= eff_width) begin
      col_count_next = '0;
      row_count_next = (rnext >= eff_width) ? '0 : rnext[AW-1:0];
    end else begin
      col_count_next = cinc[AW-1:0];
      row_count_next = row1;
    end
  end

  // Frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      col_count   <= '0;
      current_tag <= '0;
    end else if (in_acc) begin
      row_count   <= row_count_next;
      col_count   <= col_count_next;
      current_tag <= tag0;
    end
  end

  // Entry stage to read-back stage, with forwarding of a same-column write.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (en) begin
      s1_valid <= in_acc;
      fwd_hit  <= in_acc && s1_valid && (col1 == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cell  <= cells.cell_alive;
      s1_row   <= row1;
      s1_col   <= col1;
      s1_tag   <= tag0;
      fwd_data <= colbits[LW-1:0];
    end
  end

  // Column bits: the new cell under the cells stored above it.
  assign old_bits = fwd_hit ? fwd_data : ram_rdata;
  assign colbits  = {old_bits, s1_cell};

  // Line store write port: clearing pass or write-back.
  assign ram_we    = clearing || (en && s1_valid);
  assign ram_waddr = clearing ? clr_addr : s1_col;
  assign ram_wdata = clearing ? '0 : colbits[LW-1:0];

  rbtm_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (col1),
    .rdata (ram_rdata)
  );

  // Window shift: every row moves one column and takes its new cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        for (int k = 0; k < MP; k++) begin
          win[k] <= {win[k][MP-2:0], colbits[k]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_row <= s1_row;
      s2_col <= s1_col;
      s2_tag <= s1_tag;
    end
  end

  // Four parallel rotation compares on the window register.
  always_comb begin
    mism = '0;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < MP; k++) begin
        for (int j = 0; j < MP; j++) begin
          mism[r] = mism[r] |
                    ((win[k][j] ^ rot_exp[r][k*PAT_SIDE+j]) & care[k*PAT_SIDE+j]);
        end
      end
    end
    hit_mask = ~mism;
  end

  // The window fits when its bottom-right cell is at least p-1 in from the edge.
  assign top_row  = XW'(s2_row) + XW'(1) - XW'(eff_size);
  assign left_col = XW'(s2_col) + XW'(1) - XW'(eff_size);
  assign fits     = (eff_size != '0) &&
                    (XW'(s2_row) + XW'(1) >= XW'(eff_size)) &&
                    (XW'(s2_col) + XW'(1) >= XW'(eff_size));
  assign s2_hit   = s2_valid && fits && (hit_mask != '0);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en) begin
      results.valid <= s2_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      results.match_row     <= top_row[POS_W-1:0];
      results.match_col     <= left_col[POS_W-1:0];
      results.rotation_mask <= hit_mask;
      results.match_frame   <= s2_tag;
    end
  end

  // Checks on the pipeline and the clearing pass.
  `RBTM_ASSERT_SAME(a_clear_blocks_input, clk, rst, clearing, !cells.ready, "input during clear")
  `RBTM_ASSERT_SAME(a_clear_no_writeback, clk, rst, clearing, !s1_valid, "writeback in clear")
  `RBTM_ASSERT_SAME(a_fwd_has_owner, clk, rst, fwd_hit, s1_valid, "forward without a beat")
  `RBTM_ASSERT_SAME(a_mask_nonzero, clk, rst, results.valid, |results.rotation_mask, "empty mask")
  `RBTM_ASSERT_NEXT(a_hit_reaches_output, clk, rst, en && s2_hit, results.valid, "match lost")

endmodule
